@@ hdl/u8u16_pkg.sv @@
`timescale 1ns / 1ps
// package for the utf-8 to utf-16 transcoder
// field widths, register indexes, reset values and unicode constants; no dependencies

package u8u16_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CpW    = 21;
  localparam int unsigned PendW  = 2;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgErrorMode = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgReplChar  = 1'b1;

  // configuration reset values
  localparam logic             ErrorModeRst = 1'b0;
  localparam logic [UnitW-1:0] ReplCharRst  = 16'hFFFD;

  // lead byte classes
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Val  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Val  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Val  = 8'hF0;
  localparam logic [ByteW-1:0] ContMark  = 8'h80;

  // code point ranges and surrogate bases
  localparam logic [CpW-1:0]   CpMax      = 21'h10FFFF;
  localparam logic [CpW-1:0]   SuppBase   = 21'h010000;
  localparam logic [UnitW-1:0] HiSurrBase = 16'hD800;
  localparam logic [UnitW-1:0] LoSurrBase = 16'hDC00;

endpackage

@@ hdl/utf8_to_utf16_transcoder.sv @@
`timescale 1ns / 1ps
// utf-8 byte stream to utf-16 code unit transcoder, top level
// depends on u8u16_pkg for widths, register indexes and unicode constants
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / byte_in_i) takes one utf-8 byte per
//   transaction. Output channel (out_valid_o / out_stall_i) gives one utf-16 code
//   unit per transaction with the code point it belongs to, an error flag and a
//   last-unit marker. A surrogate pair leaves as two transactions, high half first.
//   Config channel (cfg_valid_i / cfg_ready_o), always ready, writes error_mode
//   (index 0) or replacement_char (index 1); the user writes it only while idle, unchecked.
// Timing:
//   A byte is held in an input register, decoded combinationally and its result lands
//   in a result register, from which the first unit is presented. One byte is taken
//   per cycle while in_stall_o is low; the single result register gives one unit per
//   cycle while out_stall_i is low, so a surrogate pair holds it until both halves are
//   taken and a byte that ends a character meanwhile waits in the input register.
// Reset: clears the pending count, accumulator, both registers' valid bits and
//   restores error_mode to 0 and replacement_char to 0xFFFD.
// Stall: when out_stall_i holds the result register, a byte that would make a
//   result waits in the input register and in_stall_o rises; bytes in the middle
//   of a sequence still advance.

module utf8_to_utf16_transcoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // byte input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [u8u16_pkg::ByteW-1:0]     byte_in_i,
  // code unit output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [u8u16_pkg::UnitW-1:0]     code_unit_o,
  output logic [u8u16_pkg::CpW-1:0]       code_point_o,
  output logic                            error_flag_o,
  output logic                            last_unit_o,
  // configuration writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [u8u16_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [u8u16_pkg::CfgDataW-1:0]  cfg_data_i
);

  import u8u16_pkg::*;

  // configuration registers
  logic             err_mode_q;
  logic [UnitW-1:0] repl_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_mode_q <= ErrorModeRst;
      repl_q     <= ReplCharRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgErrorMode: err_mode_q <= cfg_data_i[0];
        CfgReplChar:  repl_q     <= cfg_data_i[UnitW-1:0];
        default:      ;
      endcase
    end
  end

  // input register
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             advance;

  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= byte_in_i;
    end
  end

  // sequence state
  logic [PendW-1:0] pend_q, pend_d;
  logic [CpW-1:0]   acc_q, acc_d;

  // decode of the held byte
  logic             produces;
  logic             is_err;
  logic [CpW-1:0]   cp;
  logic [CpW-1:0]   folded;
  logic [CpW-1:0]   off;

  always_comb begin
    folded   = {acc_q[CpW-7:0], 6'b0} | {{(CpW-ByteW){1'b0}}, in_byte_q ^ ContMark};
    pend_d   = pend_q;
    acc_d    = acc_q;
    produces = 1'b0;
    is_err   = 1'b0;
    cp       = '0;
    if (pend_q != '0) begin
      pend_d = pend_q - PendW'(1);
      if (pend_q == PendW'(1)) begin
        produces = 1'b1;
        cp       = folded;
        acc_d    = '0;
      end else begin
        acc_d = folded;
      end
    end else begin
      priority if (!in_byte_q[ByteW-1]) begin
        produces = 1'b1;
        cp       = {{(CpW-ByteW){1'b0}}, in_byte_q};
      end else if ((in_byte_q & Lead2Mask) == Lead2Val) begin
        acc_d  = {{(CpW-ByteW){1'b0}}, in_byte_q ^ Lead2Val};
        pend_d = PendW'(1);
      end else if ((in_byte_q & Lead3Mask) == Lead3Val) begin
        acc_d  = {{(CpW-ByteW){1'b0}}, in_byte_q ^ Lead3Val};
        pend_d = PendW'(2);
      end else if ((in_byte_q & Lead4Mask) == Lead4Val) begin
        acc_d  = {{(CpW-ByteW){1'b0}}, in_byte_q ^ Lead4Val};
        pend_d = PendW'(3);
      end else begin
        produces = 1'b1;
        is_err   = 1'b1;
        acc_d    = '0;
      end
    end
    if (cp > CpMax) begin
      is_err = 1'b1;
    end
    off = cp - SuppBase;
  end

  // result register: one character, one or two units
  logic             res_valid_q;
  logic             res_pair_q;
  logic             res_phase_q;
  logic [UnitW-1:0] res_hi_q;
  logic [UnitW-1:0] res_lo_q;
  logic [CpW-1:0]   res_cp_q;
  logic             res_err_q;
  logic             out_fire;
  logic             res_free;

  assign out_fire = out_valid_o && !out_stall_i;
  assign res_free = !res_valid_q || (out_fire && last_unit_o);
  assign advance  = in_valid_q && (!produces || res_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      acc_q  <= '0;
    end else if (advance) begin
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      res_phase_q <= 1'b0;
    end else if (advance && produces) begin
      res_valid_q <= 1'b1;
      res_phase_q <= 1'b0;
    end else if (out_fire && last_unit_o) begin
      res_valid_q <= 1'b0;
    end else if (out_fire) begin
      res_phase_q <= 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (advance && produces) begin
      priority if (is_err && err_mode_q) begin
        res_pair_q <= 1'b0;
        res_lo_q   <= '0;
        res_hi_q   <= '0;
        res_cp_q   <= '0;
        res_err_q  <= 1'b1;
      end else if (is_err) begin
        res_pair_q <= 1'b0;
        res_lo_q   <= repl_q;
        res_hi_q   <= repl_q;
        res_cp_q   <= {{(CpW-UnitW){1'b0}}, repl_q};
        res_err_q  <= 1'b0;
      end else if (cp >= SuppBase) begin
        res_pair_q <= 1'b1;
        res_hi_q   <= HiSurrBase | {6'b0, off[19:10]};
        res_lo_q   <= LoSurrBase | {6'b0, off[9:0]};
        res_cp_q   <= cp;
        res_err_q  <= 1'b0;
      end else begin
        res_pair_q <= 1'b0;
        res_lo_q   <= cp[UnitW-1:0];
        res_hi_q   <= cp[UnitW-1:0];
        res_cp_q   <= cp;
        res_err_q  <= 1'b0;
      end
    end
  end

  // output selection
  assign out_valid_o  = res_valid_q;
  assign last_unit_o  = !(res_pair_q && !res_phase_q);
  assign code_unit_o  = last_unit_o ? res_lo_q : res_hi_q;
  assign code_point_o = res_cp_q;
  assign error_flag_o = res_err_q;

`ifndef NO_ASSERTIONS
  // the low half of a pair follows its high half
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !last_unit_o |=> out_valid_o && last_unit_o)
    else $error("high surrogate not followed by low surrogate");

  // an error result carries zero data and closes the character
  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> last_unit_o && code_unit_o == '0 && code_point_o == '0)
    else $error("malformed error result");

  // a high half is in the high surrogate range and belongs to a supplementary point
  a_hi_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_unit_o |->
      code_unit_o[UnitW-1:10] == HiSurrBase[UnitW-1:10] && code_point_o >= SuppBase
      && !error_flag_o)
    else $error("bad high surrogate");

  // nothing is gathered while no sequence is pending
  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> acc_q == '0)
    else $error("accumulator not empty between characters");
`endif

endmodule

@@ tb/utf8_to_utf16_transcoder_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the utf-8 to utf-16 transcoder
// depends on u8u16_pkg and utf8_to_utf16_transcoder; directed table, then random phases

module utf8_to_utf16_transcoder_tb;
  import u8u16_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int SettleCycles = 4;     // a unit leaves after its byte passes both registers; plus margin
  localparam int HoldCycles   = 120;   // long receiver hold-off to fill the block
  localparam int WatchLimit   = 1000;  // longest legal quiet stretch is the hold-off plus gaps
  localparam int NumPhases    = 6;
  localparam int PhaseBytes   = 254;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic [CpW-1:0]   code_point;
    logic             error_flag;
    logic             last_unit;
  } unit_t;

  typedef enum logic [1:0] {RowByte, RowFixed, RowCfg} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    logic [ByteW-1:0] data;
    logic             mode;
    logic [UnitW-1:0] repl;
    unit_t            want;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ByteW-1:0]    byte_in_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [UnitW-1:0]    code_unit_o;
  logic [CpW-1:0]      code_point_o;
  logic                error_flag_o;
  logic                last_unit_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // transcoder state mirrored by the predictor
  logic             err_flag_mode = ErrorModeRst;
  logic [UnitW-1:0] repl_unit     = ReplCharRst;
  logic [PendW-1:0] cont_left     = '0;
  logic [CpW-1:0]   cp_gather     = '0;

  unit_t units_due[$];
  int    errors        = 0;
  int    bytes_sent    = 0;
  int    units_checked = 0;
  int    cfg_writes    = 0;
  int    in_held       = 0;
  int    idle_cycles   = 0;
  bit    quiet         = 1'b0;
  bit    hold_req      = 1'b0;

  utf8_to_utf16_transcoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .code_unit_o  (code_unit_o),
    .code_point_o (code_point_o),
    .error_flag_o (error_flag_o),
    .last_unit_o  (last_unit_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic unit_t mk_unit(input logic [UnitW-1:0] cu, input logic [CpW-1:0] cp,
                                    input logic err, input logic last);
    unit_t u;
    u.code_unit  = cu;
    u.code_point = cp;
    u.error_flag = err;
    u.last_unit  = last;
    return u;
  endfunction

  function automatic unit_t invalid_unit();
    if (err_flag_mode) return mk_unit('0, '0, 1'b1, 1'b1);
    return mk_unit(repl_unit, CpW'(repl_unit), 1'b0, 1'b1);
  endfunction

  // predicts the units one byte causes and advances the mirrored state
  function automatic int transcode_byte(input logic [ByteW-1:0] b, output unit_t u0,
                                        output unit_t u1);
    logic [CpW-1:0] cp;
    logic [CpW-1:0] off;
    u0 = '0;
    u1 = '0;
    cp = '0;
    if (cont_left != 0) begin
      // every byte inside a sequence is folded in unchecked
      cp_gather = {cp_gather[CpW-7:0], 6'b0} | CpW'(b ^ ContMark);
      cont_left = cont_left - 2'd1;
      if (cont_left != 0) return 0;
      cp = cp_gather;
      cp_gather = '0;
    end else if (!b[7]) begin
      cp = CpW'(b);
    end else if ((b & Lead2Mask) == Lead2Val) begin
      cp_gather = CpW'(b ^ Lead2Val);
      cont_left = 2'd1;
      return 0;
    end else if ((b & Lead3Mask) == Lead3Val) begin
      cp_gather = CpW'(b ^ Lead3Val);
      cont_left = 2'd2;
      return 0;
    end else if ((b & Lead4Mask) == Lead4Val) begin
      cp_gather = CpW'(b ^ Lead4Val);
      cont_left = 2'd3;
      return 0;
    end else begin
      cp_gather = '0;
      u0 = invalid_unit();
      return 1;
    end
    // finished character: single unit, surrogate pair or out of range
    if (cp > CpMax) begin
      u0 = invalid_unit();
      return 1;
    end
    if (cp < SuppBase) begin
      u0 = mk_unit(cp[UnitW-1:0], cp, 1'b0, 1'b1);
      return 1;
    end
    off = cp - SuppBase;
    u0 = mk_unit(UnitW'(off[19:10]) | HiSurrBase, cp, 1'b0, 1'b0);
    u1 = mk_unit(UnitW'(off[9:0]) | LoSurrBase, cp, 1'b0, 1'b1);
    return 2;
  endfunction

  function automatic row_t byte_row(input logic [ByteW-1:0] b);
    row_t r;
    r.kind = RowByte;
    r.data = b;
    r.mode = 1'b0;
    r.repl = '0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t fixed_row(input logic [ByteW-1:0] b, input logic [UnitW-1:0] cu,
                                     input logic [CpW-1:0] cp, input logic err);
    row_t r;
    r = byte_row(b);
    r.kind = RowFixed;
    r.want = mk_unit(cu, cp, err, 1'b1);
    return r;
  endfunction

  function automatic row_t cfg_row(input logic mode, input logic [UnitW-1:0] repl);
    row_t r;
    r = byte_row('0);
    r.kind = RowCfg;
    r.mode = mode;
    r.repl = repl;
    return r;
  endfunction

  // offer one byte, record its expected units once accepted, then maybe pause
  task automatic push_byte(input logic [ByteW-1:0] b, input bit fixed, input unit_t want);
    unit_t u0;
    unit_t u1;
    int    n;
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      in_held++;
      @(posedge clk_i);
    end
    n = transcode_byte(b, u0, u1);
    if (fixed) begin
      units_due.push_back(want);
    end else begin
      if (n > 0) units_due.push_back(u0);
      if (n > 1) units_due.push_back(u1);
    end
    bytes_sent++;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // wait until every expected unit has left, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (units_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // idle-only register update, both registers back to back
  task automatic set_config(input logic mode, input logic [UnitW-1:0] repl);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgErrorMode;
    cfg_data_i  <= CfgDataW'(mode);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    err_flag_mode = mode;
    cfg_index_i <= CfgReplChar;
    cfg_data_i  <= repl;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    repl_unit = repl;
    cfg_writes += 2;
    cfg_valid_i <= 1'b0;
  endtask

  // one random character: mostly well-formed, some with broken continuations, some noise
  task automatic send_char();
    logic [CpW-1:0]   cp;
    logic [ByteW-1:0] seq[4];
    int               len;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      push_byte(ByteW'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    len = $urandom_range(1, 4);
    case (len)
      1: begin
        cp = CpW'($urandom_range(0, 16'h7F));
        seq[0] = cp[7:0];
      end
      2: begin
        cp = CpW'($urandom_range(0, 16'h7FF));
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        cp = CpW'($urandom_range(0, 16'hFFFF));
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        cp = CpW'($urandom_range(0, ($urandom_range(0, 3) == 0) ? 21'h1FFFFF : 21'h10FFFF));
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < len; i++) begin
      if (i > 0 && pick < 20) seq[i][7:6] = 2'($urandom_range(0, 3));
      push_byte(seq[i], 1'b0, '0);
    end
  endtask

  // output side: random stall bursts, one long hold-off on request, unit checking
  initial begin
    unit_t want;
    int    stall_left;
    int    hold_left;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        units_checked++;
        if (units_due.size() == 0) begin
          if (errors < 10)
            $display("unexpected unit %h cp %h err %b last %b", code_unit_o, code_point_o,
                     error_flag_o, last_unit_o);
          errors++;
        end else begin
          want = units_due.pop_front();
          if (want.code_unit != code_unit_o || want.code_point != code_point_o ||
              want.error_flag != error_flag_o || want.last_unit != last_unit_o) begin
            if (errors < 10)
              $display("mismatch: want %h cp %h err %b last %b, got %h cp %h err %b last %b",
                       want.code_unit, want.code_point, want.error_flag, want.last_unit,
                       code_unit_o, code_point_o, error_flag_o, last_unit_o);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin
    while (idle_cycles < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout after %0d idle cycles, %0d units still due", idle_cycles,
             units_due.size());
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus: reset, directed table, random phases, final drain
  initial begin
    row_t             rows[$];
    logic             mode_sel[NumPhases];
    logic [UnitW-1:0] repl_sel[NumPhases];
    int               target;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset configuration: extremes, a bad lead, every length and the unchecked forms
    rows.push_back(fixed_row(8'h00, 16'h0000, 21'h0, 1'b0));
    rows.push_back(fixed_row(8'h80, 16'hFFFD, 21'hFFFD, 1'b0));
    rows.push_back(byte_row(8'hC2));
    rows.push_back(byte_row(8'hA9));
    rows.push_back(byte_row(8'hF0));
    rows.push_back(byte_row(8'h9F));
    rows.push_back(byte_row(8'h98));
    rows.push_back(byte_row(8'h80));
    // highest scalar value as a surrogate pair
    rows.push_back(byte_row(8'hF4));
    rows.push_back(byte_row(8'h8F));
    rows.push_back(byte_row(8'hBF));
    rows.push_back(byte_row(8'hBF));
    // encoded surrogate and overlong zero pass through
    rows.push_back(byte_row(8'hED));
    rows.push_back(byte_row(8'hA0));
    rows.push_back(byte_row(8'h80));
    rows.push_back(byte_row(8'hC0));
    rows.push_back(byte_row(8'h80));
    // lead byte and ascii byte taken as continuations
    rows.push_back(byte_row(8'hE0));
    rows.push_back(byte_row(8'hF0));
    rows.push_back(byte_row(8'h41));
    // error-flagged mode: bad lead and code point past the top
    rows.push_back(cfg_row(1'b1, 16'hFFFD));
    rows.push_back(fixed_row(8'hFF, 16'h0000, 21'h0, 1'b1));
    rows.push_back(byte_row(8'hF7));
    rows.push_back(byte_row(8'hBF));
    rows.push_back(byte_row(8'hBF));
    rows.push_back(fixed_row(8'hBF, 16'h0000, 21'h0, 1'b1));
    // replacement inside the surrogate range, then zero
    rows.push_back(cfg_row(1'b0, 16'hD800));
    rows.push_back(fixed_row(8'hF8, 16'hD800, 21'hD800, 1'b0));
    rows.push_back(cfg_row(1'b0, 16'h0000));
    rows.push_back(fixed_row(8'h80, 16'h0000, 21'h0, 1'b0));

    foreach (rows[i]) begin
      if (rows[i].kind == RowCfg)
        set_config(rows[i].mode, rows[i].repl);
      else
        push_byte(rows[i].data, rows[i].kind == RowFixed, rows[i].want);
    end

    // random phases, each under its own register setting
    mode_sel = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    repl_sel = '{16'hFFFD, 16'($urandom_range(0, 16'hFFFF)), 16'h0000, 16'hFFFF,
                 16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF))};
    for (int p = 0; p < NumPhases; p++) begin
      set_config(mode_sel[p], repl_sel[p]);
      quiet = (p == 3) || (p == NumPhases - 1);
      if (p == 1) hold_req = 1'b1;
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) send_char();
    end

    drain();
    repeat (2 * SettleCycles) @(posedge clk_i);

    $display("ran %0d bytes through %0d register writes, %0d code units checked",
             bytes_sent, cfg_writes, units_checked);
    $display("input held off for %0d cycles, %0d failures", in_held, errors);
    if (errors == 0 && units_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/u8u16_pkg.sv
hdl/utf8_to_utf16_transcoder.sv
tb/utf8_to_utf16_transcoder_tb.sv
